// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous block allocator
// Concurrent checks on the clock with asynchronous active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every enabled clock edge
`define CBA_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
// condition must never be seen at an enabled clock edge
`define CBA_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);
`else
`define CBA_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define CBA_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif
`endif

// ----- design/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// Contiguous block allocator package
// Defaults, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cba_pkg;

	localparam int POOL_ENTRIES_DEF = 256;
	localparam int BLOCK_BYTES_DEF  = 64;

	localparam int BYTES_W = 16;
	localparam int INDEX_W = 8;

	// read address source for the map memories
	typedef enum logic [1:0] {
		RD_PTR  = 2'd0,
		RD_PREV = 2'd1,
		RD_IDX  = 2'd2
	} rd_sel_t;

	// write action at the pointer
	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_CLEAR = 2'd1,
		WR_MARK  = 2'd2
	} wr_mode_t;

	typedef struct packed {
		logic     load;
		logic     div_mul;
		logic     div_back;
		logic     div_fix;
		logic     init_search;
		logic     probe;
		logic     scan;
		logic     seek_mark;
		logic     go_left;
		logic     free_seek;
		logic     free_len;
		rd_sel_t  rd_sel;
		wr_mode_t wr_mode;
		logic     res_valid;
		logic     res_grant;
	} cba_cmd_t;

	typedef struct packed {
		logic in_free;
		logic in_zero;
		logic too_big;
		logic search_empty;
		logic scan_hit;
		logic rem_zero;
		logic rem_last;
		logic ptr_last;
		logic mid_zero;
		logic prev_free;
		logic idx_oob;
		logic free_bad;
	} cba_sts_t;

endpackage

// ----- design/contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Contiguous block allocator
// Hands out and takes back runs of consecutive pool blocks, tracked by a
// free bit and a run length per entry.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  request  | start & !busy           | op, request_bytes, free_index
//  result   | done (one cycle)        | granted, start_index
//
//  After reset the maps are swept, one entry a cycle; busy stays high
//  until the sweep ends. A free checks the entry at the index and clears
//  its run (refused if the index is out of range, the entry free or its
//  run zero). An allocate divides the size, then per probe scans up to
//  the first busy entry (and looks at the entry before a clean run), then
//  marks n entries: bounded by the single read port. A zero-size request
//  is answered in the cycle after it is taken.
//  The result is shown for one cycle with done; the receiver cannot stall,
//  and a new item may be taken in the same cycle as done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module contiguous_block_allocator #(
	parameter int POOL_ENTRIES = cba_pkg::POOL_ENTRIES_DEF,
	parameter int BLOCK_BYTES  = cba_pkg::BLOCK_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [cba_pkg::BYTES_W-1:0] request_bytes,
	input  logic [cba_pkg::INDEX_W-1:0] free_index,
	output logic                        done,
	output logic                        granted,
	output logic [cba_pkg::INDEX_W-1:0] start_index
);

	cba_pkg::cba_cmd_t cmd;
	cba_pkg::cba_sts_t sts;

	// sequencer: owns the state and the handshake towards the requester
	cba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// maps, divider, search bounds and the result register
	cba_datapath #(
		.POOL_ENTRIES (POOL_ENTRIES),
		.BLOCK_BYTES  (BLOCK_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.request_bytes (request_bytes),
		.free_index    (free_index),
		.done          (done),
		.granted       (granted),
		.start_index   (start_index)
	);

	// a result only follows work in hand or an item just taken
	`CBA_ASSERT(a_done_after_work, clk, arst_n, done |-> $past(busy || start), "result without item")
	// a refused item reports index zero
	`CBA_NEVER(a_fail_index_zero, clk, arst_n, done && !granted && (start_index != '0), "fail with index")
	// a taken item either answers at once or keeps the block busy
	`CBA_ASSERT(a_accept_trace, clk, arst_n, (start && !busy) |=> (done || busy), "item lost")

endmodule

// ----- design/cba_datapath.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Map memories, size divider, search bounds, scan pointer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cba_datapath #(
	parameter int POOL_ENTRIES = cba_pkg::POOL_ENTRIES_DEF,
	parameter int BLOCK_BYTES  = cba_pkg::BLOCK_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cba_pkg::cba_cmd_t            cmd,
	output cba_pkg::cba_sts_t            sts,
	input  logic                         op,
	input  logic [cba_pkg::BYTES_W-1:0]  request_bytes,
	input  logic [cba_pkg::INDEX_W-1:0]  free_index,
	output logic                         done,
	output logic                         granted,
	output logic [cba_pkg::INDEX_W-1:0]  start_index
);

	localparam int BYW       = cba_pkg::BYTES_W;
	localparam int IXW       = cba_pkg::INDEX_W;
	localparam int AW        = $clog2(POOL_ENTRIES);
	localparam int CW        = $clog2(POOL_ENTRIES + 1);
	localparam int BW        = $clog2(BLOCK_BYTES + 1);
	localparam int DIV_SHIFT = BYW + $clog2(BLOCK_BYTES);
	localparam int RECIP_W   = BYW + 1;
	localparam int PROD_W    = BYW + RECIP_W;
	localparam int QB_W      = BYW + BW;
	localparam int NW        = BYW + 1;

	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_SHIFT) / BLOCK_BYTES);
	localparam logic [BW-1:0]      BLK   = BW'(BLOCK_BYTES);
	localparam logic [CW-1:0]      POOL  = CW'(POOL_ENTRIES);
	localparam logic [AW-1:0]      LAST  = AW'(POOL_ENTRIES - 1);

	// map memories
	logic          free_mem [POOL_ENTRIES];
	logic [CW-1:0] rl_mem   [POOL_ENTRIES];

	logic                op_q;
	logic [BYW-1:0]      x_q;
	logic [IXW-1:0]      idx_q;
	logic [PROD_W-1:0]   prod_s1;
	logic [BYW-1:0]      q_s2;
	logic [QB_W-1:0]     qb_s2;
	logic [NW-1:0]       n_q;
	logic [CW-1:0]       left_q;
	logic [CW-1:0]       right_q;
	logic [AW-1:0]       mid_q;
	logic [AW-1:0]       ptr_q;
	logic [CW-1:0]       rem_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;
	logic                fm_rd_s1;
	logic [CW-1:0]       rl_rd_s1;
	logic                done_q;
	logic                granted_q;
	logic [IXW-1:0]      start_q;

	logic [PROD_W-1:0]   q_full;
	logic [QB_W-1:0]     rmd;
	logic                carry;
	logic [NW-1:0]       n_nxt;
	logic [CW-1:0]       n_c;
	logic [CW-1:0]       mid_sum;
	logic [AW-1:0]       mid_prev;
	logic [AW+IXW-1:0]   idx_w;
	logic [AW-1:0]       idx_a;
	logic [CW-1:0]       avail;
	logic [CW-1:0]       clip;
	logic [AW+IXW-1:0]   mid_w;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic                wr_free;
	logic [CW-1:0]       wr_len;

	// ceil division: q = floor((bytes-1)/B) is at most one short, fixed by the remainder
	assign q_full   = prod_s1 >> DIV_SHIFT;
	assign rmd      = QB_W'(x_q) - qb_s2;
	assign carry    = rmd >= QB_W'(BLK);
	assign n_nxt    = NW'(q_s2) + NW'(1) + NW'(carry);
	assign n_c      = n_q[CW-1:0];

	assign mid_sum  = left_q + ((right_q - left_q) >> 1);
	assign mid_prev = mid_q - AW'(1);
	assign idx_w    = {{AW{1'b0}}, idx_q};
	assign idx_a    = idx_w[AW-1:0];
	assign avail    = POOL - CW'(idx_a);
	assign clip     = (rl_rd_s1 > avail) ? avail : rl_rd_s1;
	assign mid_w    = {{IXW{1'b0}}, mid_q};

	always_comb begin
		case (cmd.rd_sel)
			cba_pkg::RD_PTR:  rd_addr = ptr_q;
			cba_pkg::RD_PREV: rd_addr = mid_prev;
			cba_pkg::RD_IDX:  rd_addr = idx_a;
			default:          rd_addr = ptr_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_mode)
			cba_pkg::WR_CLEAR: begin
				wr_en   = 1'b1;
				wr_free = 1'b1;
				wr_len  = '0;
			end
			cba_pkg::WR_MARK: begin
				wr_en   = 1'b1;
				wr_free = 1'b0;
				wr_len  = n_c;
			end
			default: begin
				wr_en   = 1'b0;
				wr_free = 1'b1;
				wr_len  = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			free_mem[ptr_q] <= wr_free;
			rl_mem[ptr_q]   <= wr_len;
		end
		fm_rd_s1 <= free_mem[rd_addr];
		rl_rd_s1 <= rl_mem[rd_addr];
	end

	// request capture and size divider
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			x_q   <= request_bytes - BYW'(1);
			idx_q <= free_index;
		end
		if (cmd.div_mul) begin
			prod_s1 <= PROD_W'(x_q) * PROD_W'(RECIP);
		end
		if (cmd.div_back) begin
			q_s2  <= q_full[BYW-1:0];
			qb_s2 <= QB_W'(q_full[BYW-1:0]) * QB_W'(BLK);
		end
		if (cmd.div_fix) begin
			n_q <= n_nxt;
		end
	end

	// search bounds
	always_ff @(posedge clk) begin
		if (cmd.init_search) begin
			left_q  <= '0;
			right_q <= POOL - n_c;
		end else if (cmd.go_left) begin
			right_q <= CW'(mid_prev);
		end else if (cmd.scan && sts.scan_hit) begin
			left_q <= CW'(addr_s1) + CW'(1);
		end
		if (cmd.probe) begin
			mid_q <= mid_sum[AW-1:0];
		end
	end

	// walking pointer and count; ptr starts at zero for the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			rem_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan && (rem_q != '0);
			if (wr_en) begin
				ptr_q <= ptr_q + AW'(1);
				rem_q <= rem_q - CW'(1);
			end else if (cmd.probe) begin
				ptr_q <= mid_sum[AW-1:0];
				rem_q <= n_c;
			end else if (cmd.scan) begin
				if (rem_q != '0) begin
					ptr_q <= ptr_q + AW'(1);
					rem_q <= rem_q - CW'(1);
				end
			end else if (cmd.seek_mark) begin
				ptr_q <= mid_q;
				rem_q <= n_c;
			end else if (cmd.free_seek) begin
				ptr_q <= idx_a;
			end else if (cmd.free_len) begin
				rem_q <= clip;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_valid) begin
			granted_q <= cmd.res_grant;
			if (!cmd.res_grant) begin
				start_q <= '0;
			end else if (op_q) begin
				start_q <= idx_q;
			end else begin
				start_q <= mid_w[IXW-1:0];
			end
		end
	end

	assign done        = done_q;
	assign granted     = granted_q;
	assign start_index = start_q;

	always_comb begin
		sts.in_free      = op;
		sts.in_zero      = request_bytes == '0;
		sts.too_big      = n_q > NW'(POOL_ENTRIES);
		sts.search_empty = left_q > right_q;
		sts.scan_hit     = vld_s1 && !fm_rd_s1;
		sts.rem_zero     = rem_q == '0;
		sts.rem_last     = rem_q == CW'(1);
		sts.ptr_last     = ptr_q == LAST;
		sts.mid_zero     = mid_q == '0;
		sts.prev_free    = fm_rd_s1;
		sts.idx_oob      = {{CW{1'b0}}, idx_q} >= (CW + IXW)'(POOL_ENTRIES);
		sts.free_bad     = fm_rd_s1 || (rl_rd_s1 == '0);
	end

endmodule

// ----- design/cba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences clearing, size division, probe/scan search, marking and release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cba_pkg::cba_sts_t sts,
	output cba_pkg::cba_cmd_t cmd,
	output logic              busy
);

	typedef enum logic [12:0] {
		ST_CLEAR    = 13'b0000000000001,
		ST_IDLE     = 13'b0000000000010,
		ST_DIV1     = 13'b0000000000100,
		ST_DIV2     = 13'b0000000001000,
		ST_DIV3     = 13'b0000000010000,
		ST_INIT     = 13'b0000000100000,
		ST_PROBE    = 13'b0000001000000,
		ST_SCAN     = 13'b0000010000000,
		ST_LEFT     = 13'b0000100000000,
		ST_MARK     = 13'b0001000000000,
		ST_FREE_RD  = 13'b0010000000000,
		ST_FREE_CHK = 13'b0100000000000,
		ST_RELEASE  = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_mode = cba_pkg::WR_CLEAR;
				if (sts.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (sts.in_free) begin
						state_d = ST_FREE_RD;
					end else if (sts.in_zero) begin
						cmd.res_valid = 1'b1;
					end else begin
						state_d = ST_DIV1;
					end
				end
			end
			ST_DIV1: begin
				cmd.div_mul = 1'b1;
				state_d     = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_back = 1'b1;
				state_d      = ST_DIV3;
			end
			ST_DIV3: begin
				cmd.div_fix = 1'b1;
				state_d     = ST_INIT;
			end
			ST_INIT: begin
				if (sts.too_big) begin
					cmd.res_valid = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.init_search = 1'b1;
					state_d         = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (sts.search_empty) begin
					cmd.res_valid = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.probe = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_hit) begin
					// busy entry: bounds move past it, in-flight read dropped
					cmd.scan = 1'b1;
					state_d  = ST_PROBE;
				end else if (sts.rem_zero) begin
					cmd.seek_mark = 1'b1;
					cmd.rd_sel    = cba_pkg::RD_PREV;
					state_d       = sts.mid_zero ? ST_MARK : ST_LEFT;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_LEFT: begin
				if (sts.prev_free) begin
					cmd.go_left = 1'b1;
					state_d     = ST_PROBE;
				end else begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				cmd.wr_mode = cba_pkg::WR_MARK;
				if (sts.rem_last) begin
					cmd.res_valid = 1'b1;
					cmd.res_grant = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_FREE_RD: begin
				if (sts.idx_oob) begin
					cmd.res_valid = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.rd_sel    = cba_pkg::RD_IDX;
					cmd.free_seek = 1'b1;
					state_d       = ST_FREE_CHK;
				end
			end
			ST_FREE_CHK: begin
				if (sts.free_bad) begin
					cmd.res_valid = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.free_len = 1'b1;
					state_d      = ST_RELEASE;
				end
			end
			ST_RELEASE: begin
				cmd.wr_mode = cba_pkg::WR_CLEAR;
				if (sts.rem_last) begin
					cmd.res_valid = 1'b1;
					cmd.res_grant = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
